>>> hdl/joystick_axis_to_motion_packet_core_macros.svh
// Assertion helpers for the motion packet core.
`ifndef JOYSTICK_AXIS_TO_MOTION_PACKET_CORE_MACROS_SVH
`define JOYSTICK_AXIS_TO_MOTION_PACKET_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define JAMP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define JAMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define JAMP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define JAMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/jamp_pkg.sv
package jamp_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int SPEED_W        = 7;
    localparam int VALUE_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int WINDOW_LEN_DEF = 3;

    localparam logic [SAMPLE_W-1:0] CENTER = 12'd2048;
    localparam int                  CENTER_SHIFT = 11;
    localparam logic [7:0]          PKT_HEAD = 8'hA0;
    localparam logic [7:0]          PKT_TAIL = 8'hFF;

    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RST = 12'd800;
    localparam logic [SPEED_W-1:0]  MAX_SPEED_RST = 7'd50;
    localparam logic                AXIS_ID_RST   = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ID   = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dead_zone;
        logic [SPEED_W-1:0]  max_speed;
        logic                axis_id;
    } t_cfg;

    typedef struct packed {
        logic               axis_id;
        logic [VALUE_W-1:0] value;
    } t_desc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_AXIS,
        ST_HIGH,
        ST_LOW,
        ST_TAIL
    } t_state;

endpackage

>>> hdl/joystick_axis_to_motion_packet_core.sv
// Joystick axis to motion packet.
// Input channel (i_valid/o_ready, i_sample): one 12-bit ADC sample per transaction.
// Output channel (o_valid/i_ready, o_out_byte, o_last_byte): packet bytes A0, axis id,
// value high, value low, FF; o_last_byte marks the FF byte.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): always ready;
// index 0 dead zone, 1 max speed, 2 axis id, other indexes ignored.
// The first WINDOW_LEN samples only fill the averaging window and produce nothing.
// Samples are taken one per cycle while o_ready is high, through a three-stage front
// pipeline; a packet's bytes are then shown one per cycle while the receiver is ready.
// The byte serializer sets the sustained packet rate; a two-entry packet queue sits
// between pipeline and serializer.
// When the receiver stalls, the current byte holds; the queue then fills and o_ready
// drops once a packet cannot be queued.
// Reset (synchronous, active low) clears window, queue and serializer and loads the
// register defaults: dead zone 800, max speed 50, axis id 0.
module joystick_axis_to_motion_packet_core
    import jamp_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_byte,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "joystick_axis_to_motion_packet_core_macros.svh"

    t_cfg  r_cfg;
    logic  w_push;
    t_desc w_push_desc;
    logic  w_q_ready;
    logic  w_pop;
    t_desc w_pop_desc;
    logic  w_q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone <= DEAD_ZONE_RST;
            r_cfg.max_speed <= MAX_SPEED_RST;
            r_cfg.axis_id   <= AXIS_ID_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEAD_ZONE: r_cfg.dead_zone <= i_cfg_data;
                CFG_MAX_SPEED: r_cfg.max_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_AXIS_ID:   r_cfg.axis_id   <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    jamp_front #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .o_push    (w_push),
        .o_desc    (w_push_desc),
        .i_q_ready (w_q_ready)
    );

    jamp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_desc  (w_pop_desc),
        .o_valid (w_q_valid)
    );

    jamp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_desc      (w_pop_desc),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    // a packet the queue cannot take holds the front, so none is dropped
    `JAMP_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, w_push && !w_q_ready, !o_ready)
    // the final byte of a packet is always the tail marker
    `JAMP_ASSERT_SAME(a_tail_byte, i_clk, i_rst_n, o_valid && o_last_byte,
                      o_out_byte == PKT_TAIL)
    // after a tail is taken, the next byte shown starts a new packet
    `JAMP_ASSERT_NEXT(a_head_follows, i_clk, i_rst_n, o_valid && o_last_byte && i_ready,
                      !o_valid || o_out_byte == PKT_HEAD)

endmodule

>>> hdl/jamp_front.sv
module jamp_front
    import jamp_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    output t_desc               o_desc,
    input  logic                i_q_ready
);

    localparam int PC_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
    // reciprocal for divide by WINDOW_LEN, exact for every SUM_W-bit sum
    localparam int RCP_S = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_M_INT = ((1 << RCP_S) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [RCP_S-1:0] RCP_M = RCP_S'(RCP_M_INT);
    localparam logic [PC_W-1:0]  PRIME_FULL = PC_W'(WINDOW_LEN);
    localparam int PROD_W = SAMPLE_W + SPEED_W;

    logic [SAMPLE_W-1:0] r_taps [WINDOW_LEN];
    logic [PC_W-1:0]     r_prime;
    logic [SUM_W-1:0]    r_sum;
    logic                r_v1;
    logic [SAMPLE_W-1:0] r_avg;
    logic                r_v2;
    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic                r_still;
    logic                r_v3;
    logic                r_was_still;

    logic                        w_adv;
    logic                        w_acc;
    logic [SUM_W+RCP_S-1:0]      w_quot_prod;
    logic [SAMPLE_W-1:0]         w_mag;
    logic                        w_neg;
    logic [7:0]                  w_scaled;
    logic [SPEED_W-1:0]          w_clamped;
    logic [VALUE_W-1:0]          w_value;
    logic                        w_emit;

    // stall the whole front only when a packet cannot enter the queue
    assign w_emit  = !r_still || (r_still != r_was_still);
    assign w_adv   = !(r_v3 && w_emit && !i_q_ready);
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;

    assign w_quot_prod = {{RCP_S{1'b0}}, r_sum} * {{SUM_W{1'b0}}, RCP_M};
    assign w_neg = r_avg < CENTER;
    assign w_mag = w_neg ? (CENTER - r_avg) : (r_avg - CENTER);

    assign w_scaled  = r_prod[PROD_W-1:CENTER_SHIFT];
    assign w_clamped = (w_scaled > {1'b0, i_cfg.max_speed}) ? i_cfg.max_speed
                                                           : w_scaled[SPEED_W-1:0];
    assign w_value = r_neg ? (VALUE_W'(0) - VALUE_W'(w_clamped)) : VALUE_W'(w_clamped);

    assign o_push         = r_v3 && w_emit;
    assign o_desc.axis_id = i_cfg.axis_id;
    assign o_desc.value   = r_still ? '0 : w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_taps[k] <= '0;
            end
            r_prime     <= '0;
            r_sum       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_was_still <= 1'b1;
        end else if (w_adv) begin
            if (w_acc) begin
                r_taps[0] <= i_sample;
                for (int k = 1; k < WINDOW_LEN; k++) begin
                    r_taps[k] <= r_taps[k-1];
                end
                // oldest tap is zero while priming, so one update covers both cases
                r_sum <= r_sum + SUM_W'(i_sample) - SUM_W'(r_taps[WINDOW_LEN-1]);
                if (r_prime != PRIME_FULL) begin
                    r_prime <= r_prime + PC_W'(1);
                end
            end
            r_v1 <= w_acc && (r_prime == PRIME_FULL);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_was_still <= r_still;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_avg   <= w_quot_prod[RCP_S +: SAMPLE_W];
            r_prod  <= {{SPEED_W{1'b0}}, w_mag} * {{SAMPLE_W{1'b0}}, i_cfg.max_speed};
            r_neg   <= w_neg;
            r_still <= w_mag < i_cfg.dead_zone;
        end
    end

endmodule

>>> hdl/jamp_queue.sv
module jamp_queue
    import jamp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_valid
);

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_desc  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

>>> hdl/jamp_back.sv
module jamp_back
    import jamp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_desc,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    t_state r_state;
    t_state n_state;
    t_desc  r_desc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = i_q_valid ? ST_HEAD : ST_IDLE;
            ST_HEAD: if (i_ready) n_state = ST_AXIS;
            ST_AXIS: if (i_ready) n_state = ST_HIGH;
            ST_HIGH: if (i_ready) n_state = ST_LOW;
            ST_LOW:  if (i_ready) n_state = ST_TAIL;
            ST_TAIL: if (i_ready) n_state = i_q_valid ? ST_HEAD : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_valid     = 1'b1;
        o_last_byte = 1'b0;
        o_out_byte  = PKT_HEAD;
        unique case (r_state)
            ST_IDLE: begin
                o_valid = 1'b0;
                o_pop   = i_q_valid;
            end
            ST_HEAD: o_out_byte = PKT_HEAD;
            ST_AXIS: o_out_byte = {7'd0, r_desc.axis_id};
            ST_HIGH: o_out_byte = r_desc.value[15:8];
            ST_LOW:  o_out_byte = r_desc.value[7:0];
            ST_TAIL: begin
                o_out_byte  = PKT_TAIL;
                o_last_byte = 1'b1;
                o_pop       = i_ready && i_q_valid;
            end
            default: o_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
    end

endmodule

>>> tb/tb_top.sv
module tb_top
    import jamp_pkg::*;
();

    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int CTR          = 2048;
    localparam int SETTLE_CYC   = 12;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 33;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_pkt_byte;

    typedef enum {RX_OPEN, RX_COIN, RX_LONG, RX_SPARSE} t_rx_mode;

    // Tracks window and motion state and holds the packet bytes still owed by the core.
    class packet_checker;
        logic [SAMPLE_W-1:0] win[WIN];
        int unsigned         wpos;
        int unsigned         primed;
        bit                  was_still;
        logic [11:0]         dead_zone;
        logic [6:0]          max_speed;
        logic                axis;
        t_pkt_byte           exp_bytes[$];
        int                  errors;
        int                  samples;
        int                  moving_pkts;
        int                  still_pkts;
        int                  bytes_seen;

        function new();
            foreach (win[i]) win[i] = '0;
            wpos        = 0;
            primed      = 0;
            was_still   = 1'b1;
            dead_zone   = DEAD_ZONE_RST;
            max_speed   = MAX_SPEED_RST;
            axis        = AXIS_ID_RST;
            errors      = 0;
            samples     = 0;
            moving_pkts = 0;
            still_pkts  = 0;
            bytes_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEAD_ZONE: dead_zone = data;
                CFG_MAX_SPEED: max_speed = data[6:0];
                CFG_AXIS_ID:   axis = data[0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] data, logic last);
            t_pkt_byte b;
            b.data = data;
            b.last = last;
            exp_bytes.push_back(b);
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            int unsigned sum;
            int unsigned avg;
            int unsigned mag;
            int unsigned speed;
            bit          neg;
            bit          still;
            logic [15:0] val;
            samples++;
            if (primed < WIN) begin
                win[primed] = s;
                primed++;
                return;
            end
            win[wpos] = s;
            wpos = (wpos + 1) % WIN;
            sum = 0;
            foreach (win[i]) sum += win[i];
            avg = sum / WIN;
            neg = avg < CTR;
            mag = neg ? CTR - avg : avg - CTR;
            still = mag < dead_zone;
            speed = still ? 0 : (mag * max_speed) / CTR;
            if (speed > max_speed) speed = max_speed;
            val = 16'(speed);
            if (neg) val = -val;
            if (still && was_still) begin
                return;
            end
            was_still = still;
            if (still) still_pkts++;
            else moving_pkts++;
            push_byte(PKT_HEAD, 1'b0);
            push_byte({7'd0, axis}, 1'b0);
            push_byte(val[15:8], 1'b0);
            push_byte(val[7:0], 1'b0);
            push_byte(PKT_TAIL, 1'b1);
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_pkt_byte b;
            bytes_seen++;
            if (exp_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b", $time, data, last);
                errors++;
                return;
            end
            b = exp_bytes.pop_front();
            if (data !== b.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, b.data, data);
                errors++;
            end
            if (last !== b.last) begin
                $display("%0t: last_byte expected %0b actual %0b", $time, b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return exp_bytes.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_last_byte;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    packet_checker       board;
    logic [SAMPLE_W-1:0] stim_q[$];
    int                  burst_left = 0;
    int                  reg_writes = 0;
    t_rx_mode            rx_mode = RX_OPEN;
    int                  rx_left = 0;
    int                  rx_stall = 0;

    joystick_axis_to_motion_packet_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver backpressure, switching between patterns every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            i_ready  <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: i_ready <= 1'b1;
                RX_COIN: i_ready <= 1'($urandom_range(0, 1));
                RX_LONG: begin
                    if ($urandom_range(0, 9) == 0) begin
                        rx_stall <= $urandom_range(4, 24);
                        i_ready  <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_byte(o_out_byte, o_last_byte);
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        board.take_sample(s);
        @(negedge i_clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // sends everything in stim_q; optionally holds off halfway until the core is empty
    task automatic play_samples(input bit hold_mid);
        int n;
        int k;
        n = stim_q.size();
        @(negedge i_clk);
        for (k = 0; k < n; k++) begin
            send_sample(stim_q[k]);
            if (k == n - 1) begin
                i_valid <= 1'b0;
            end else if (hold_mid && k == n / 2) begin
                i_valid <= 1'b0;
                drain();
                @(negedge i_clk);
            end else begin
                pace();
            end
        end
        stim_q.delete();
        drain();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev,
                                                        input int dz);
        int band;
        int off;
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: return 12'($urandom_range(0, 4095));
            3: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            4, 5: begin
                // hover around the dead zone edge
                band = (dz > 2047) ? 2047 : dz;
                off = band + $urandom_range(0, 80) - 40;
                if (off < 0) off = 0;
                v = $urandom_range(0, 1) ? CTR + off : CTR - off;
            end
            6: return prev;
            default: v = CTR + $urandom_range(0, 4094) - 2047;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    initial begin
        #(12 * 600000);
        $display("FAIL joystick_axis_to_motion_packet_core");
        $finish;
    end

    initial begin
        int                  p;
        int                  k;
        int                  dz;
        int                  ms;
        logic [SAMPLE_W-1:0] prev;
        board = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // priming, full-scale both ways, settle into the dead zone, tiny offset
        stim_q = '{12'd0, 12'd4095, 12'd2048,
                   12'd4095, 12'd4095, 12'd4095,
                   12'd0, 12'd0, 12'd0,
                   12'd2048, 12'd2048, 12'd2048, 12'd2047};
        play_samples(1'b0);
        // zero dead zone: centered axis still moves, with value 0
        write_reg(CFG_DEAD_ZONE, 12'd0);
        stim_q = '{12'd2048, 12'd2047};
        play_samples(1'b0);
        // dead zone beyond full scale: always still
        write_reg(CFG_DEAD_ZONE, 12'd4095);
        stim_q = '{12'd4095, 12'd4095};
        play_samples(1'b0);
        // zero gain
        write_reg(CFG_MAX_SPEED, 12'd0);
        write_reg(CFG_DEAD_ZONE, 12'd0);
        write_reg(CFG_SPARE, 12'hFFF);
        stim_q = '{12'd0, 12'd4095};
        play_samples(1'b0);
        // dead zone exactly 2048: only a full negative swing moves
        write_reg(CFG_MAX_SPEED, 12'd127);
        write_reg(CFG_AXIS_ID, 12'd1);
        write_reg(CFG_DEAD_ZONE, 12'd2048);
        stim_q = '{12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0};
        play_samples(1'b0);

        prev = 12'd2048;
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: dz = 0;
                1: dz = 2048;
                2: dz = 4095;
                3: dz = 1;
                default: dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 2048);
            endcase
            case (p)
                1: ms = 127;
                2: ms = 1;
                4: ms = 0;
                default: ms = $urandom_range(1, 127);
            endcase
            write_reg(CFG_DEAD_ZONE, 12'(dz));
            write_reg(CFG_MAX_SPEED, 12'(ms));
            write_reg(CFG_AXIS_ID, 12'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 12'($urandom_range(0, 4095)));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                prev = pick_sample(prev, dz);
                stim_q.push_back(prev);
            end
            play_samples(p == 5);
        end

        if (board.pending() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, board.pending());
            board.errors++;
        end
        $display("Run covered %0d samples and %0d register writes across several settings.",
                 board.samples, reg_writes);
        $display("Checked %0d bytes: %0d moving packets, %0d still packets.",
                 board.bytes_seen, board.moving_pkts, board.still_pkts);
        if (board.errors == 0) begin
            $display("PASS joystick_axis_to_motion_packet_core");
        end else begin
            $display("FAIL joystick_axis_to_motion_packet_core");
        end
        $finish;
    end

endmodule
